[design/bge_pkg.sv]
// Shared types, constants and saturation helpers for the breakpoint gain envelope.
`default_nettype none
package bge_pkg;

    localparam int SOURCES_DEF  = 32;
    localparam int SEGMENTS_DEF = 64;

    localparam logic [30:0] POS_END = 31'h7fffffff;
    localparam logic signed [31:0] ONE_Q16 = 32'sh00010000;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_BEYOND = 2'd2;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] S24_MAX = 64'sd8388607;
    localparam logic signed [63:0] S24_MIN = -64'sd8388608;

    typedef enum logic [1:0] {
        MODE_FACTOR = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_CLOSE  = 2'd2,
        MODE_SAMPLE = 2'd3
    } mode_t;

    // one stored segment
    typedef struct packed {
        logic [30:0]        seg_start;
        logic [30:0]        seg_end;
        logic signed [31:0] seg_level;
        logic signed [47:0] seg_slope;
    } seg_t;

    // classified input item
    typedef struct packed {
        mode_t              mode;
        logic               src_ok;
        logic [4:0]         source;
        logic [30:0]        position;
        logic signed [31:0] level;
        logic signed [23:0] sample;
    } item_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX)
            return 32'sh7fffffff;
        else if (v < S32_MIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > S24_MAX)
            return 24'sh7fffff;
        else if (v < S24_MIN)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

endpackage
`default_nettype wire

[design/bge_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bge_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/bge_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module bge_front #(
    parameter int SOURCES = bge_pkg::SOURCES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         mode,
    input  wire logic [4:0]         source,
    input  wire logic [30:0]        position,
    input  wire logic signed [31:0] level,
    input  wire logic signed [23:0] sample_in,
    output bge_pkg::item_t          q,
    output logic                    q_valid,
    input  wire logic               q_pop
);

    bge_pkg::item_t slot_reg [2];
    bge_pkg::item_t wr_next;
    logic [1:0] count_reg, count_next;
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic       wr, rd;

    // classify the incoming item
    always_comb
    begin
        wr_next.mode     = bge_pkg::mode_t'(mode);
        wr_next.src_ok   = (32'(source) < SOURCES);
        wr_next.source   = source;
        wr_next.position = position;
        wr_next.level    = level;
        wr_next.sample   = sample_in;
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q       = slot_reg[rptr_reg];
    assign wr      = push && !full;
    assign rd      = q_pop && q_valid;

    // queue pointers
    always_comb
    begin
        wptr_next  = wr ? !wptr_reg : wptr_reg;
        rptr_next  = rd ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wr_next;
        end
    end

endmodule
`default_nettype wire

[design/bge_div.sv]
// Slope divider: (dy * 2^24) / dx, truncated, saturated to 48 bits, one bit a cycle.
`default_nettype none
module bge_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] dy,
    input  wire logic signed [31:0] dx,
    output logic                    done,
    output logic signed [47:0]      q
);

    localparam int NB = 57;
    localparam logic [56:0] POS_LIM = 57'h7fffffffffff;
    localparam logic [56:0] NEG_LIM = 57'h800000000000;

    logic [NB-1:0]      num_reg, num_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        den_reg, den_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic signed [47:0] q_reg, q_next;
    logic [32:0]        dy_mag;
    logic [31:0]        dx_mag;
    logic [32:0]        trial;

    assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
    assign dx_mag = dx[31] ? 32'(-dx) : 32'(dx);
    assign trial  = {rem_reg, num_reg[NB-1]};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        neg_next  = neg_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        if (start)
        begin
            if (dx == 32'sd0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else
            begin
                num_next  = {dy_mag, 24'b0};
                den_next  = dx_mag;
                rem_next  = '0;
                cnt_next  = 6'(NB);
                busy_next = 1'b1;
                neg_next  = dy[32] ^ dx[31];
            end
        end
        else if (busy_reg)
        begin
            // restoring step
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                num_next = {num_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                num_next = {num_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // sign and saturate the quotient
            if (!neg_reg)
                q_next = (num_reg > POS_LIM) ? 48'sh7fffffffffff : num_reg[47:0];
            else
                q_next = (num_reg > NEG_LIM) ? 48'sh800000000000 : 48'(-num_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

[design/bge_back.sv]
// Back end: per-source state, segment store, table loading and sample gain.
`default_nettype none
module bge_back #(
    parameter int SOURCES  = bge_pkg::SOURCES_DEF,
    parameter int SEGMENTS = bge_pkg::SEGMENTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  bge_pkg::item_t          q,
    input  wire logic               q_valid,
    output logic                    q_pop,
    output logic signed [23:0]      sample_out,
    output logic                    clipped,
    output logic [1:0]              status,
    output logic                    out_valid,
    input  wire logic               out_pop
);

    localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int IW    = $clog2(SEGMENTS);
    localparam int CW    = $clog2(SEGMENTS + 1);
    localparam int DEPTH = SOURCES * SEGMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SEG_W = $bits(bge_pkg::seg_t);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_OPEN = 12'b000000000010,
        ST_LRD  = 12'b000000000100,
        ST_LCHK = 12'b000000001000,
        ST_DIV  = 12'b000000010000,
        ST_SRD  = 12'b000000100000,
        ST_SCHK = 12'b000001000000,
        ST_ENV  = 12'b000010000000,
        ST_GAIN = 12'b000100000000,
        ST_GSAT = 12'b001000000000,
        ST_OMUL = 12'b010000000000,
        ST_OSAT = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // per-source state
    logic [CW-1:0]      count_reg  [SOURCES];
    logic [CW-1:0]      count_next [SOURCES];
    logic [IW-1:0]      cur_reg    [SOURCES];
    logic [IW-1:0]      cur_next   [SOURCES];
    logic signed [31:0] factor_reg [SOURCES];
    logic signed [31:0] factor_next[SOURCES];
    logic signed [31:0] tail_reg   [SOURCES];
    logic signed [31:0] tail_next  [SOURCES];
    logic [SOURCES-1:0] on_reg, on_next;
    logic [SOURCES-1:0] closed_reg, closed_next;

    // item working registers
    bge_pkg::item_t     it_reg, it_next;
    logic [IW-1:0]      c_reg, c_next;
    logic               first_reg, first_next;
    bge_pkg::seg_t      ent_reg, ent_next;
    logic [AW-1:0]      waddr_reg, waddr_next;
    logic signed [31:0] tnew_reg, tnew_next;
    logic               append_reg, append_next;
    logic [54:0]        lo_reg, lo_next;
    logic signed [56:0] hi_reg, hi_next;
    logic signed [31:0] env_reg, env_next;
    logic signed [63:0] gp_reg, gp_next;
    logic signed [31:0] g_reg, g_next;
    logic signed [55:0] op_reg, op_next;

    // result register
    logic               ovalid_reg, ovalid_next;
    logic signed [23:0] osample_reg, osample_next;
    logic               oclip_reg, oclip_next;
    logic [1:0]         ostatus_reg, ostatus_next;

    // segment store and divider
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    bge_pkg::seg_t      ram_wdata;
    logic [SEG_W-1:0]   ram_rdata;
    bge_pkg::seg_t      rd_seg;
    logic               div_start, div_done;
    logic signed [32:0] div_dy;
    logic signed [31:0] div_dx;
    logic signed [47:0] div_q;

    logic [SW-1:0]      s_idx, qs;
    logic [AW-1:0]      base;
    logic [30:0]        d;
    logic [30:0]        new_end;
    logic signed [31:0] new_lvl;
    logic signed [57:0] env_sum;
    logic signed [63:0] v64;

    assign rd_seg = bge_pkg::seg_t'(ram_rdata);
    assign s_idx  = SW'(it_reg.source);
    assign qs     = SW'(q.source);
    assign base   = AW'(s_idx) * AW'(SEGMENTS);
    assign d      = it_reg.position - rd_seg.seg_start;

    bge_ram #(
        .W(SEG_W),
        .D(DEPTH)
    ) u_seg_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bge_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .dy   (div_dy),
        .dx   (div_dx),
        .done (div_done),
        .q    (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        factor_next  = factor_reg;
        tail_next    = tail_reg;
        on_next      = on_reg;
        closed_next  = closed_reg;
        it_next      = it_reg;
        c_next       = c_reg;
        first_next   = first_reg;
        ent_next     = ent_reg;
        waddr_next   = waddr_reg;
        tnew_next    = tnew_reg;
        append_next  = append_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        env_next     = env_reg;
        gp_next      = gp_reg;
        g_next       = g_reg;
        op_next      = op_reg;
        ovalid_next  = (out_pop && ovalid_reg) ? 1'b0 : ovalid_reg;
        osample_next = osample_reg;
        oclip_next   = oclip_reg;
        ostatus_next = ostatus_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = waddr_reg;
        ram_wdata    = ent_reg;
        ram_raddr    = '0;
        div_start    = 1'b0;
        div_dy       = '0;
        div_dx       = '0;
        new_end      = bge_pkg::POS_END;
        new_lvl      = '0;
        env_sum      = '0;
        v64          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    q_pop      = 1'b1;
                    it_next    = q;
                    first_next = 1'b1;
                    if (!q.src_ok)
                    begin
                        ovalid_next  = 1'b1;
                        osample_next = '0;
                        oclip_next   = 1'b0;
                        ostatus_next = bge_pkg::STAT_OK;
                    end
                    else
                    begin
                        case (q.mode)
                            bge_pkg::MODE_FACTOR:
                            begin
                                factor_next[qs] = q.level;
                                count_next[qs]  = '0;
                                cur_next[qs]    = '0;
                                on_next[qs]     = 1'b0;
                                closed_next[qs] = 1'b0;
                                ovalid_next     = 1'b1;
                                osample_next    = '0;
                                oclip_next      = 1'b0;
                                ostatus_next    = bge_pkg::STAT_OK;
                            end
                            bge_pkg::MODE_LOAD, bge_pkg::MODE_CLOSE:
                            begin
                                state_next = on_reg[qs] ? ST_LRD : ST_OPEN;
                            end
                            default:
                            begin
                                if (!on_reg[qs])
                                begin
                                    g_next     = factor_reg[qs];
                                    state_next = ST_OMUL;
                                end
                                else
                                begin
                                    c_next = (CW'(cur_reg[qs]) >= count_reg[qs]) ?
                                             '0 : cur_reg[qs];
                                    state_next = ST_SRD;
                                end
                            end
                        endcase
                    end
                end
            end

            // start an empty table with a null first segment
            ST_OPEN:
            begin
                ram_we             = 1'b1;
                ram_waddr          = base;
                ram_wdata          = '0;
                waddr_next         = base;
                count_next[s_idx]  = CW'(1);
                cur_next[s_idx]    = '0;
                tail_next[s_idx]   = '0;
                on_next[s_idx]     = 1'b1;
                closed_next[s_idx] = 1'b0;
                state_next         = ST_LRD;
            end

            ST_LRD:
            begin
                if (closed_reg[s_idx])
                begin
                    ovalid_next  = 1'b1;
                    osample_next = '0;
                    oclip_next   = 1'b0;
                    ostatus_next = (it_reg.mode == bge_pkg::MODE_LOAD) ?
                                   bge_pkg::STAT_FULL : bge_pkg::STAT_OK;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = base + AW'(count_reg[s_idx] - CW'(1));
                    state_next = ST_LCHK;
                end
            end

            // last segment in hand: repeat, refuse or append
            ST_LCHK:
            begin
                if (it_reg.mode == bge_pkg::MODE_LOAD &&
                    it_reg.position == rd_seg.seg_end)
                begin
                    ent_next    = rd_seg;
                    waddr_next  = base + AW'(count_reg[s_idx] - CW'(1));
                    append_next = 1'b0;
                    tnew_next   = it_reg.level;
                    div_start   = 1'b1;
                    div_dy      = {it_reg.level[31], it_reg.level} -
                                  {rd_seg.seg_level[31], rd_seg.seg_level};
                    div_dx      = {1'b0, rd_seg.seg_end} - {1'b0, rd_seg.seg_start};
                    state_next  = ST_DIV;
                end
                else if (it_reg.mode == bge_pkg::MODE_LOAD &&
                         count_reg[s_idx] >= CW'(SEGMENTS - 1))
                begin
                    ovalid_next  = 1'b1;
                    osample_next = '0;
                    oclip_next   = 1'b0;
                    ostatus_next = bge_pkg::STAT_FULL;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    if (it_reg.mode == bge_pkg::MODE_LOAD)
                    begin
                        new_end = it_reg.position;
                        new_lvl = it_reg.level;
                    end
                    ent_next.seg_start = rd_seg.seg_end;
                    ent_next.seg_end   = new_end;
                    ent_next.seg_level = tail_reg[s_idx];
                    ent_next.seg_slope = '0;
                    waddr_next         = base + AW'(count_reg[s_idx]);
                    append_next        = 1'b1;
                    tnew_next          = new_lvl;
                    div_start          = 1'b1;
                    div_dy             = {new_lvl[31], new_lvl} -
                                         {tail_reg[s_idx][31], tail_reg[s_idx]};
                    div_dx             = {1'b0, new_end} - {1'b0, rd_seg.seg_end};
                    state_next         = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    ram_we              = 1'b1;
                    ram_wdata           = ent_reg;
                    ram_wdata.seg_slope = div_q;
                    tail_next[s_idx]    = tnew_reg;
                    if (append_reg)
                        count_next[s_idx] = count_reg[s_idx] + CW'(1);
                    if (it_reg.mode == bge_pkg::MODE_CLOSE)
                        closed_next[s_idx] = 1'b1;
                    ovalid_next  = 1'b1;
                    osample_next = '0;
                    oclip_next   = 1'b0;
                    ostatus_next = bge_pkg::STAT_OK;
                    state_next   = ST_IDLE;
                end
            end

            ST_SRD:
            begin
                ram_raddr  = base + AW'(c_reg);
                state_next = ST_SCHK;
            end

            // segment search: restart check, then walk forward
            ST_SCHK:
            begin
                first_next = 1'b0;
                if (first_reg && it_reg.position < rd_seg.seg_start)
                begin
                    c_next     = '0;
                    state_next = ST_SRD;
                end
                else if (it_reg.position >= rd_seg.seg_start &&
                         it_reg.position < rd_seg.seg_end)
                begin
                    cur_next[s_idx] = c_reg;
                    ent_next        = rd_seg;
                    lo_next         = rd_seg.seg_slope[23:0] * d;
                    hi_next         = $signed(rd_seg.seg_slope[47:24]) * $signed({1'b0, d});
                    state_next      = ST_ENV;
                end
                else if (CW'(c_reg) + CW'(1) >= count_reg[s_idx])
                begin
                    ovalid_next  = 1'b1;
                    osample_next = '0;
                    oclip_next   = 1'b0;
                    ostatus_next = closed_reg[s_idx] ? bge_pkg::STAT_OK :
                                   bge_pkg::STAT_BEYOND;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    c_next     = c_reg + IW'(1);
                    state_next = ST_SRD;
                end
            end

            // level + floor(slope * d / 2^24)
            ST_ENV:
            begin
                env_sum    = 58'(hi_reg) + 58'($signed({1'b0, lo_reg[54:24]})) +
                             58'(ent_reg.seg_level);
                env_next   = bge_pkg::sat32(64'(env_sum));
                state_next = ST_GAIN;
            end

            ST_GAIN:
            begin
                gp_next    = factor_reg[s_idx] * env_reg;
                state_next = ST_GSAT;
            end

            ST_GSAT:
            begin
                g_next     = bge_pkg::sat32(gp_reg >>> 16);
                state_next = ST_OMUL;
            end

            ST_OMUL:
            begin
                op_next    = it_reg.sample * g_reg;
                state_next = ST_OSAT;
            end

            // scale down, saturate and deliver
            ST_OSAT:
            begin
                v64          = 64'(op_reg >>> 16);
                ovalid_next  = 1'b1;
                osample_next = bge_pkg::sat24(v64);
                oclip_next   = (v64 > bge_pkg::S24_MAX) || (v64 < bge_pkg::S24_MIN);
                ostatus_next = bge_pkg::STAT_OK;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            on_reg     <= '0;
            closed_reg <= '0;
            for (int i = 0; i < SOURCES; i++)
            begin
                count_reg[i]  <= '0;
                cur_reg[i]    <= '0;
                factor_reg[i] <= bge_pkg::ONE_Q16;
                tail_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            on_reg     <= on_next;
            closed_reg <= closed_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            factor_reg <= factor_next;
            tail_reg   <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg      <= it_next;
        c_reg       <= c_next;
        first_reg   <= first_next;
        ent_reg     <= ent_next;
        waddr_reg   <= waddr_next;
        tnew_reg    <= tnew_next;
        append_reg  <= append_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        env_reg     <= env_next;
        gp_reg      <= gp_next;
        g_reg       <= g_next;
        op_reg      <= op_next;
        osample_reg <= osample_next;
        oclip_reg   <= oclip_next;
        ostatus_reg <= ostatus_next;
    end

    assign out_valid  = ovalid_reg;
    assign sample_out = osample_reg;
    assign clipped    = oclip_reg;
    assign status     = ostatus_reg;

endmodule
`default_nettype wire

[design/breakpoint_gain_envelope.sv]
// Top level of the per-source breakpoint gain envelope.
//
// Each item sets a source's fixed factor, loads or closes its breakpoint table, or
// scales one sample; every item gives one result item. Items enter a two-deep queue
// and the back end works on one at a time. A sample item with a table waits on the
// registered read of the segment RAM for every segment the search visits and on the
// multiply chain. A load or close item waits on the bit-serial slope divider (57
// steps), and one that opens the table first writes a null first segment. Segment
// entries are undefined until loaded; no clearing pass is needed after reset.
`default_nettype none
module breakpoint_gain_envelope #(
    parameter int SOURCES  = bge_pkg::SOURCES_DEF,
    parameter int SEGMENTS = bge_pkg::SEGMENTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         mode,
    input  wire logic [4:0]         source,
    input  wire logic [30:0]        position,
    input  wire logic signed [31:0] level,
    input  wire logic signed [23:0] sample_in,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [23:0]      sample_out,
    output logic                    clipped,
    output logic [1:0]              status
);

    bge_pkg::item_t q;
    logic           q_valid;
    logic           q_pop;
    logic           out_valid;

    bge_front #(
        .SOURCES(SOURCES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .mode     (mode),
        .source   (source),
        .position (position),
        .level    (level),
        .sample_in(sample_in),
        .q        (q),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    bge_back #(
        .SOURCES (SOURCES),
        .SEGMENTS(SEGMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .sample_out(sample_out),
        .clipped   (clipped),
        .status    (status),
        .out_valid (out_valid),
        .out_pop   (pop)
    );

    assign empty = !out_valid;

endmodule
`default_nettype wire
